/* hw/rtl/msmi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package msmi_pkg;

   localparam int POS_W   = 18;
   localparam int XB      = 8;
   localparam int X_W     = POS_W + XB;
   localparam int DIFF_W  = X_W + 1;
   localparam int STEP_W  = 32;
   localparam int TICK_W  = 16;
   localparam int DIV_W   = 53;
   localparam int PIQ_W   = 26;
   localparam int DUR_W   = DIV_W;

   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [9:0]  MS_PER_S    = 10'd1000;

   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_MOVE  = 3'd1;
   localparam logic [2:0] KIND_QUERY = 3'd2;
   localparam logic [2:0] KIND_ESTOP = 3'd3;
   localparam logic [2:0] KIND_STOP  = 3'd4;

   localparam logic REG_PULSE_MIN = 1'b0;
   localparam logic REG_PULSE_MAX = 1'b1;

   typedef enum logic [2:0] {
      RS_REPORT      = 3'd0,
      RS_BUSY        = 3'd1,
      RS_IDLE        = 3'd2,
      RS_ACCEPTED    = 3'd3,
      RS_BAD_CHANNEL = 3'd4,
      RS_ZERO_TIME   = 3'd5,
      RS_STOP_IDLE   = 3'd6
   } rsp_status_type;

   typedef enum logic [1:0] {
      DIV_ANGLE,
      DIV_SPEED,
      DIV_STEP
   } div_sel_type;

   typedef enum logic [1:0] {
      EM_TICK,
      EM_CHAN,
      EM_BAD,
      EM_PLAIN
   } emit_sel_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_MUL_A,
      S_DIV_A,
      S_WAIT_A,
      S_TGT,
      S_DIFF,
      S_MUL_S1,
      S_MUL_S2,
      S_DIV_S,
      S_WAIT_S,
      S_DUR,
      S_CHECK,
      S_DIV_M,
      S_WAIT_M,
      S_COMMIT,
      S_EM_ACC,
      S_EM_BAD,
      S_EM_ZERO,
      S_STOP,
      S_EM_IDLECH,
      S_ESTOP,
      S_EM_ESTOP,
      S_EM_QUERY,
      S_TICK_UPD,
      S_TICK_EM
   } ctrl_state_type;

   typedef struct packed {
      logic           load_req;
      logic           walk_clr;
      logic           ch_inc;
      logic           mul_a;
      logic           div_start;
      div_sel_type    div_sel;
      logic           take_angle;
      logic           calc_diff;
      logic           mul_s1;
      logic           mul_s2;
      logic           calc_dur;
      logic           commit;
      logic           stop_ch;
      logic           halt_all;
      logic           tick_step;
      logic           emit;
      emit_sel_type   emit_sel;
      rsp_status_type emit_status;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       bad_ch;
      logic       span_zero;
      logic       speed_ok;
      logic       dur_zero;
      logic       ticks_zero;
      logic       div_busy;
      logic       ch_active;
      logic       any_active;
      logic       last_ch;
      logic       slot_free;
   } dp_status_type;

endpackage
`default_nettype wire

/* hw/rtl/msmi_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module msmi_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [msmi_pkg::DIV_W-1:0]   num,
   input  wire logic [msmi_pkg::DIV_W-1:0]   den,
   output logic                              busy,
   output logic [msmi_pkg::DIV_W-1:0]        quo
);

   localparam int W    = msmi_pkg::DIV_W;
   localparam int CNTW = $clog2(W);

   logic            busy_ff, busy_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    den_ff, den_in;
   logic [W:0]      trial;
   logic [W:0]      diffv;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[W-1]};
      ge      = trial >= {1'b0, den_ff};
      diffv   = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(W - 1);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = ge ? diffv[W-1:0] : trial[W-1:0];
         quo_in  = {quo_ff[W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

/* hw/rtl/msmi_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module msmi_dp #(
   parameter int NUM_CHANNELS = 6,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire msmi_pkg::dp_cmd_type          cmd,
   output msmi_pkg::dp_status_type            st,
   input  wire logic [15:0]                   pulse_min,
   input  wire logic [15:0]                   pulse_max,
   input  wire logic [2:0]                    req_kind,
   input  wire logic [4:0]                    req_channel,
   input  wire logic [15:0]                   req_pulse_width,
   input  wire logic                          req_has_time,
   input  wire logic [15:0]                   req_move_time,
   input  wire logic                          req_has_speed,
   input  wire logic [15:0]                   req_speed,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [4:0]                         rsp_report_channel,
   output logic signed [msmi_pkg::POS_W-1:0]  rsp_position,
   output logic                               rsp_channel_moving,
   output logic                               rsp_last
);

   localparam int CW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int POS_W  = msmi_pkg::POS_W;
   localparam int XB     = msmi_pkg::XB;
   localparam int X_W    = msmi_pkg::X_W;
   localparam int DIFF_W = msmi_pkg::DIFF_W;
   localparam int STEP_W = msmi_pkg::STEP_W;
   localparam int TICK_W = msmi_pkg::TICK_W;
   localparam int DW     = msmi_pkg::DIV_W;
   localparam int PIQ_W  = msmi_pkg::PIQ_W;
   localparam int RSH    = 30 - FRAC_BITS;
   localparam logic [33:0] RND = 34'(1) << (29 - FRAC_BITS);
   localparam logic [33:0] PIQ_FULL = (34'(msmi_pkg::PI_Q30) + RND) >> RSH;
   localparam logic [PIQ_W-1:0] PIQ = PIQ_FULL[PIQ_W-1:0];
   localparam logic signed [X_W:0] XMAX = (X_W+1)'((33'sd1 <<< (X_W - 1)) - 33'sd1);
   localparam logic signed [X_W:0] XMIN = (X_W+1)'(-(33'sd1 <<< (X_W - 1)));
   localparam logic signed [POS_W-1:0] POS_MAX = (18'sd1 <<< (POS_W - 1)) - 18'sd1;
   localparam logic signed [POS_W-1:0] POS_MIN = -(18'sd1 <<< (POS_W - 1));

   logic [2:0]  kind_ff;
   logic [4:0]  ch_ff;
   logic [15:0] pw_ff, mt_ff, spd_ff;
   logic        ht_ff, hs_ff;
   logic [CW-1:0] idx_ff;

   logic signed [X_W-1:0]   x_ff    [NUM_CHANNELS];
   logic signed [POS_W-1:0] tgt_ff  [NUM_CHANNELS];
   logic [STEP_W-1:0]       step_ff [NUM_CHANNELS];
   logic [TICK_W-1:0]       ticks_ff[NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] act_ff;

   logic [47:0]              proda_ff;
   logic signed [POS_W-1:0]  ang_ff, ang_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [DIFF_W-1:0]        dist_ff;
   logic [42:0]              p1_ff;
   logic [41:0]              sden_ff;
   logic [DW-1:0]            p2_ff;
   logic [DW-1:0]            dur_ff, dur_in;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [4:0]  rsp_ch_ff;
   logic signed [POS_W-1:0] rsp_pos_ff;
   logic        rsp_mov_ff, rsp_last_ff;

   logic [15:0] span, pw_c, pw_off;
   logic        span_zero, speed_ok, slot_free;
   logic [DW-1:0] div_num, div_den, quo;
   logic        div_busy;
   logic signed [X_W-1:0] xcur;
   logic [32:0]           t_val;
   logic signed [33:0]    s_val;
   logic [32:0]           mag;
   logic [33:0]           rnd_val;
   logic [DW-1:0]         dur_t;
   logic [STEP_W-1:0]     m32, step_new;
   logic [TICK_W-1:0]     ticks_new;
   logic signed [X_W:0]   sum;
   logic signed [X_W-1:0] x_step;

   assign span      = (pulse_max > pulse_min) ? pulse_max - pulse_min : '0;
   assign span_zero = span == '0;
   assign pw_c      = (pw_ff < pulse_min) ? pulse_min :
                      ((pw_ff > pulse_max) ? pulse_max : pw_ff);
   assign pw_off    = pw_c - pulse_min;
   assign speed_ok  = hs_ff & (spd_ff != '0) & ~span_zero;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign xcur      = x_ff[idx_ff];

   always_comb begin
      unique case (cmd.div_sel)
         msmi_pkg::DIV_ANGLE: begin
            div_num = DW'(proda_ff);
            div_den = DW'(span);
         end
         msmi_pkg::DIV_SPEED: begin
            div_num = p2_ff;
            div_den = DW'(sden_ff);
         end
         msmi_pkg::DIV_STEP: begin
            div_num = DW'({dist_ff, 8'b0});
            div_den = dur_ff;
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   msmi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (quo)
   );

   always_comb begin
      t_val   = span_zero ? '0 : quo[32:0];
      s_val   = $signed({1'b0, t_val}) - $signed({2'b0, msmi_pkg::HALF_PI_Q30});
      mag     = s_val[33] ? 33'(-s_val) : s_val[32:0];
      rnd_val = (34'(mag) + RND) >> RSH;
      if (s_val[33]) begin
         ang_in = (rnd_val > 34'd131072) ? POS_MIN : POS_W'(-rnd_val);
      end else begin
         ang_in = (rnd_val > 34'd131071) ? POS_MAX : POS_W'(rnd_val);
      end
      diff_in   = DIFF_W'($signed({ang_ff, 8'b0})) - DIFF_W'(xcur);
      dur_t     = ht_ff ? DW'({mt_ff, 8'b0}) : '0;
      dur_in    = (speed_ok && quo > dur_t) ? quo : dur_t;
      m32       = quo[STEP_W-1:0];
      step_new  = diff_ff[DIFF_W-1] ? -m32 : m32;
      ticks_new = (|dur_ff[DW-1:XB+TICK_W]) ? '1 : dur_ff[XB+TICK_W-1:XB];
      sum       = (X_W+1)'(xcur) + (X_W+1)'($signed(step_ff[idx_ff]));
      if (sum > XMAX) begin
         x_step = XMAX[X_W-1:0];
      end else if (sum < XMIN) begin
         x_step = XMIN[X_W-1:0];
      end else begin
         x_step = sum[X_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         ch_ff   <= req_channel;
         pw_ff   <= req_pulse_width;
         mt_ff   <= req_move_time;
         spd_ff  <= req_speed;
         ht_ff   <= req_has_time;
         hs_ff   <= req_has_speed;
      end
      if (cmd.mul_a) begin
         proda_ff <= 48'(pw_off) * 48'(msmi_pkg::PI_Q30);
      end
      if (cmd.take_angle) begin
         ang_ff <= ang_in;
      end
      if (cmd.calc_diff) begin
         diff_ff <= diff_in;
         dist_ff <= diff_in[DIFF_W-1] ? DIFF_W'(-diff_in) : DIFF_W'(diff_in);
      end
      if (cmd.mul_s1) begin
         p1_ff   <= 43'(dist_ff) * 43'(span);
         sden_ff <= 42'(spd_ff) * 42'(PIQ);
      end
      if (cmd.mul_s2) begin
         p2_ff <= DW'(p1_ff) * DW'(msmi_pkg::MS_PER_S);
      end
      if (cmd.calc_dur) begin
         dur_ff <= dur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.load_req) begin
         idx_ff <= req_channel[CW-1:0];
      end else if (cmd.walk_clr) begin
         idx_ff <= '0;
      end else if (cmd.ch_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            x_ff[i]     <= '0;
            tgt_ff[i]   <= '0;
            step_ff[i]  <= '0;
            ticks_ff[i] <= '0;
         end
         act_ff <= '0;
      end else if (cmd.halt_all) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            step_ff[i]  <= '0;
            ticks_ff[i] <= '0;
         end
         act_ff <= '0;
      end else if (cmd.stop_ch) begin
         step_ff[idx_ff]  <= '0;
         ticks_ff[idx_ff] <= '0;
         act_ff[idx_ff]   <= 1'b0;
      end else if (cmd.commit) begin
         tgt_ff[idx_ff] <= ang_ff;
         if (dur_ff[DW-1:XB] == '0) begin
            x_ff[idx_ff]     <= {ang_ff, 8'b0};
            step_ff[idx_ff]  <= '0;
            ticks_ff[idx_ff] <= '0;
            act_ff[idx_ff]   <= 1'b0;
         end else begin
            step_ff[idx_ff]  <= step_new;
            ticks_ff[idx_ff] <= ticks_new;
            act_ff[idx_ff]   <= 1'b1;
         end
      end else if (cmd.tick_step && act_ff[idx_ff]) begin
         if (ticks_ff[idx_ff] > 16'd1) begin
            x_ff[idx_ff]     <= x_step;
            ticks_ff[idx_ff] <= ticks_ff[idx_ff] - 1'b1;
         end else begin
            x_ff[idx_ff]     <= {tgt_ff[idx_ff], 8'b0};
            step_ff[idx_ff]  <= '0;
            ticks_ff[idx_ff] <= '0;
            act_ff[idx_ff]   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit && slot_free) begin
         rsp_status_ff <= cmd.emit_status;
         unique case (cmd.emit_sel)
            msmi_pkg::EM_TICK: begin
               rsp_ch_ff   <= 5'(idx_ff);
               rsp_pos_ff  <= xcur[X_W-1:XB];
               rsp_mov_ff  <= act_ff[idx_ff];
               rsp_last_ff <= idx_ff == CW'(NUM_CHANNELS - 1);
            end
            msmi_pkg::EM_CHAN: begin
               rsp_ch_ff   <= ch_ff;
               rsp_pos_ff  <= xcur[X_W-1:XB];
               rsp_mov_ff  <= act_ff[idx_ff];
               rsp_last_ff <= 1'b1;
            end
            msmi_pkg::EM_BAD: begin
               rsp_ch_ff   <= ch_ff;
               rsp_pos_ff  <= '0;
               rsp_mov_ff  <= 1'b0;
               rsp_last_ff <= 1'b1;
            end
            default: begin
               rsp_ch_ff   <= '0;
               rsp_pos_ff  <= '0;
               rsp_mov_ff  <= 1'b0;
               rsp_last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_report_channel = rsp_ch_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_channel_moving = rsp_mov_ff;
   assign rsp_last           = rsp_last_ff;

   always_comb begin
      st.kind       = kind_ff;
      st.bad_ch     = {1'b0, ch_ff} >= 6'(NUM_CHANNELS);
      st.span_zero  = span_zero;
      st.speed_ok   = speed_ok;
      st.dur_zero   = dur_ff == '0;
      st.ticks_zero = dur_ff[DW-1:XB] == '0;
      st.div_busy   = div_busy;
      st.ch_active  = act_ff[idx_ff];
      st.any_active = |act_ff;
      st.last_ch    = idx_ff == CW'(NUM_CHANNELS - 1);
      st.slot_free  = slot_free;
   end

endmodule
`default_nettype wire

/* hw/rtl/msmi_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module msmi_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire msmi_pkg::dp_status_type st,
   output msmi_pkg::dp_cmd_type         cmd
);

   msmi_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msmi_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.div_sel     = msmi_pkg::DIV_ANGLE;
      cmd.emit_sel    = msmi_pkg::EM_PLAIN;
      cmd.emit_status = msmi_pkg::RS_REPORT;
      req_ready       = 1'b0;
      unique case (state_ff)
         msmi_pkg::S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = msmi_pkg::S_DECODE;
            end
         end
         msmi_pkg::S_DECODE: begin
            unique case (st.kind)
               msmi_pkg::KIND_TICK: begin
                  cmd.walk_clr = 1'b1;
                  state_in     = msmi_pkg::S_TICK_UPD;
               end
               msmi_pkg::KIND_MOVE: begin
                  state_in = st.bad_ch ? msmi_pkg::S_EM_BAD : msmi_pkg::S_MUL_A;
               end
               msmi_pkg::KIND_QUERY: state_in = msmi_pkg::S_EM_QUERY;
               msmi_pkg::KIND_ESTOP: state_in = msmi_pkg::S_ESTOP;
               msmi_pkg::KIND_STOP: begin
                  state_in = st.bad_ch ? msmi_pkg::S_EM_BAD : msmi_pkg::S_STOP;
               end
               default: state_in = msmi_pkg::S_IDLE;
            endcase
         end
         msmi_pkg::S_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = st.span_zero ? msmi_pkg::S_TGT : msmi_pkg::S_DIV_A;
         end
         msmi_pkg::S_DIV_A: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = msmi_pkg::DIV_ANGLE;
            state_in      = msmi_pkg::S_WAIT_A;
         end
         msmi_pkg::S_WAIT_A: begin
            if (!st.div_busy) begin
               state_in = msmi_pkg::S_TGT;
            end
         end
         msmi_pkg::S_TGT: begin
            cmd.take_angle = 1'b1;
            state_in       = msmi_pkg::S_DIFF;
         end
         msmi_pkg::S_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = st.speed_ok ? msmi_pkg::S_MUL_S1 : msmi_pkg::S_DUR;
         end
         msmi_pkg::S_MUL_S1: begin
            cmd.mul_s1 = 1'b1;
            state_in   = msmi_pkg::S_MUL_S2;
         end
         msmi_pkg::S_MUL_S2: begin
            cmd.mul_s2 = 1'b1;
            state_in   = msmi_pkg::S_DIV_S;
         end
         msmi_pkg::S_DIV_S: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = msmi_pkg::DIV_SPEED;
            state_in      = msmi_pkg::S_WAIT_S;
         end
         msmi_pkg::S_WAIT_S: begin
            if (!st.div_busy) begin
               state_in = msmi_pkg::S_DUR;
            end
         end
         msmi_pkg::S_DUR: begin
            cmd.calc_dur = 1'b1;
            state_in     = msmi_pkg::S_CHECK;
         end
         msmi_pkg::S_CHECK: begin
            priority if (st.dur_zero) begin
               state_in = msmi_pkg::S_EM_ZERO;
            end else if (st.ticks_zero) begin
               state_in = msmi_pkg::S_COMMIT;
            end else begin
               state_in = msmi_pkg::S_DIV_M;
            end
         end
         msmi_pkg::S_DIV_M: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = msmi_pkg::DIV_STEP;
            state_in      = msmi_pkg::S_WAIT_M;
         end
         msmi_pkg::S_WAIT_M: begin
            cmd.div_sel = msmi_pkg::DIV_STEP;
            if (!st.div_busy) begin
               state_in = msmi_pkg::S_COMMIT;
            end
         end
         msmi_pkg::S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = msmi_pkg::S_EM_ACC;
         end
         msmi_pkg::S_EM_ACC: begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = msmi_pkg::EM_CHAN;
            cmd.emit_status = msmi_pkg::RS_ACCEPTED;
            if (st.slot_free) begin
               state_in = msmi_pkg::S_IDLE;
            end
         end
         msmi_pkg::S_EM_BAD: begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = msmi_pkg::EM_BAD;
            cmd.emit_status = msmi_pkg::RS_BAD_CHANNEL;
            if (st.slot_free) begin
               state_in = msmi_pkg::S_IDLE;
            end
         end
         msmi_pkg::S_EM_ZERO: begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = msmi_pkg::EM_CHAN;
            cmd.emit_status = msmi_pkg::RS_ZERO_TIME;
            if (st.slot_free) begin
               state_in = msmi_pkg::S_IDLE;
            end
         end
         msmi_pkg::S_STOP: begin
            if (st.ch_active) begin
               cmd.stop_ch = 1'b1;
               state_in    = msmi_pkg::S_EM_ACC;
            end else begin
               state_in = msmi_pkg::S_EM_IDLECH;
            end
         end
         msmi_pkg::S_EM_IDLECH: begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = msmi_pkg::EM_CHAN;
            cmd.emit_status = msmi_pkg::RS_STOP_IDLE;
            if (st.slot_free) begin
               state_in = msmi_pkg::S_IDLE;
            end
         end
         msmi_pkg::S_ESTOP: begin
            cmd.halt_all = 1'b1;
            state_in     = msmi_pkg::S_EM_ESTOP;
         end
         msmi_pkg::S_EM_ESTOP: begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = msmi_pkg::EM_PLAIN;
            cmd.emit_status = msmi_pkg::RS_ACCEPTED;
            if (st.slot_free) begin
               state_in = msmi_pkg::S_IDLE;
            end
         end
         msmi_pkg::S_EM_QUERY: begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = msmi_pkg::EM_PLAIN;
            cmd.emit_status = st.any_active ? msmi_pkg::RS_BUSY : msmi_pkg::RS_IDLE;
            if (st.slot_free) begin
               state_in = msmi_pkg::S_IDLE;
            end
         end
         msmi_pkg::S_TICK_UPD: begin
            cmd.tick_step = 1'b1;
            state_in      = msmi_pkg::S_TICK_EM;
         end
         msmi_pkg::S_TICK_EM: begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = msmi_pkg::EM_TICK;
            cmd.emit_status = msmi_pkg::RS_REPORT;
            if (st.slot_free) begin
               if (st.last_ch) begin
                  state_in = msmi_pkg::S_IDLE;
               end else begin
                  cmd.ch_inc = 1'b1;
                  state_in   = msmi_pkg::S_TICK_UPD;
               end
            end
         end
         default: state_in = msmi_pkg::S_IDLE;
      endcase
   end

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !st.div_busy)
      else $error("divider started while busy");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == msmi_pkg::S_DECODE)
      else $error("accepted word not decoded");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !st.slot_free) |=> state_ff == $past(state_ff))
      else $error("result dropped while output busy");

   a_estop_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.halt_all |=> !st.any_active)
      else $error("channel still moving after emergency stop");

   a_walk_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msmi_pkg::S_TICK_EM && st.slot_free && !st.last_ch)
      |=> state_ff == msmi_pkg::S_TICK_UPD)
      else $error("tick walk ended early");

endmodule
`default_nettype wire

/* hw/rtl/multichannel_servo_move_interpolator.sv */
// Tick: one position report per channel, stepping through the channels in order.
// Move: control states plus up to three runs of the shared 53-step divider
// (angle, speed time, step); a bad channel skips the divider.
// Query, stop and emergency stop use no divider. One word is processed at a time,
// and an output stall holds it until the result is taken. Synchronous active-high
// reset: all channels at 0 and idle, pulse_min 500, pulse_max 2500.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_servo_move_interpolator #(
   parameter int NUM_CHANNELS = 6,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [2:0]                    req_kind,
   input  wire logic [4:0]                    req_channel,
   input  wire logic [15:0]                   req_pulse_width,
   input  wire logic                          req_has_time,
   input  wire logic [15:0]                   req_move_time,
   input  wire logic                          req_has_speed,
   input  wire logic [15:0]                   req_speed,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [4:0]                         rsp_report_channel,
   output logic signed [msmi_pkg::POS_W-1:0]  rsp_position,
   output logic                               rsp_channel_moving,
   output logic                               rsp_last,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [2:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   logic [15:0] pulse_min_ff, pulse_max_ff;
   logic        csr_we;
   msmi_pkg::dp_cmd_type    cmd;
   msmi_pkg::dp_status_type st;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff <= 16'd500;
         pulse_max_ff <= 16'd2500;
      end else if (csr_we) begin
         unique case (csr_paddr[2])
            msmi_pkg::REG_PULSE_MIN: pulse_min_ff <= csr_pwdata[15:0];
            msmi_pkg::REG_PULSE_MAX: pulse_max_ff <= csr_pwdata[15:0];
            default: pulse_min_ff <= pulse_min_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         msmi_pkg::REG_PULSE_MIN: csr_prdata = {16'b0, pulse_min_ff};
         msmi_pkg::REG_PULSE_MAX: csr_prdata = {16'b0, pulse_max_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   msmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   msmi_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .pulse_min          (pulse_min_ff),
      .pulse_max          (pulse_max_ff),
      .req_kind           (req_kind),
      .req_channel        (req_channel),
      .req_pulse_width    (req_pulse_width),
      .req_has_time       (req_has_time),
      .req_move_time      (req_move_time),
      .req_has_speed      (req_has_speed),
      .req_speed          (req_speed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_report_channel (rsp_report_channel),
      .rsp_position       (rsp_position),
      .rsp_channel_moving (rsp_channel_moving),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire

/* sim/multichannel_servo_move_interpolator_tb.sv */
`timescale 1ns / 1ps
module multichannel_servo_move_interpolator_tb;

   localparam int NCH = 6;
   localparam int LIMIT = 5000;
   localparam int SETTLE = 250;
   localparam logic [2:0] ADDR_PULSE_MIN = 3'd0;
   localparam logic [2:0] ADDR_PULSE_MAX = 3'd4;
   localparam logic [2:0] KIND_BOGUS5 = 3'd5;
   localparam logic [2:0] KIND_BOGUS7 = 3'd7;
   localparam longint X_LO = -131072 * 256;
   localparam longint X_HI = 131071 * 256 + 255;

   typedef struct {
      msmi_pkg::rsp_status_type st;
      logic [4:0]        ch;
      logic signed [17:0] pos;
      logic              moving;
      logic              last;
   } servo_result_type;

   typedef struct {
      logic [2:0]  kind;
      logic [4:0]  ch;
      logic [15:0] pw;
      logic        has_time;
      logic [15:0] mtime;
      logic        has_speed;
      logic [15:0] speed;
      logic        typed;
      msmi_pkg::rsp_status_type tst;
      logic signed [17:0] tpos;
   } servo_cmd_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [2:0] req_kind;
   logic [4:0] req_channel;
   logic [15:0] req_pulse_width, req_move_time, req_speed;
   logic req_has_time, req_has_speed;
   logic rsp_valid, rsp_ready;
   logic [2:0] rsp_status;
   logic [4:0] rsp_report_channel;
   logic signed [17:0] rsp_position;
   logic rsp_channel_moving, rsp_last;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   multichannel_servo_move_interpolator dut (.*);

   servo_result_type servo_expected[$];
   servo_cmd_type directed[$];
   longint cal_min, cal_max;
   longint joint_x[NCH];
   longint joint_tgt[NCH];
   longint joint_step[NCH];
   longint joint_ticks[NCH];
   bit joint_active[NCH];
   int errors;
   int idle_cycles;
   bit quiet;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic void push_result(msmi_pkg::rsp_status_type st, logic [4:0] ch,
                                       longint pos, bit moving, bit last);
      servo_result_type r;
      r.st = st;
      r.ch = ch;
      r.pos = pos[17:0];
      r.moving = moving;
      r.last = last;
      servo_expected.insert(servo_expected.size(), r);
   endfunction

   function automatic void add_row(servo_cmd_type w);
      directed.insert(directed.size(), w);
   endfunction

   function automatic longint span_now();
      return (cal_max > cal_min) ? cal_max - cal_min : 0;
   endfunction

   function automatic longint clamp_x(longint x);
      if (x < X_LO) return X_LO;
      if (x > X_HI) return X_HI;
      return x;
   endfunction

   function automatic longint angle_of(longint pw);
      longint span, t, s, r;
      span = span_now();
      t = 0;
      if (span != 0) begin
         if (pw < cal_min) pw = cal_min;
         if (pw > cal_max) pw = cal_max;
         t = (pw - cal_min) * longint'(msmi_pkg::PI_Q30) / span;
      end
      s = t - longint'(msmi_pkg::HALF_PI_Q30);
      if (s < 0) r = -((-s + 8192) >>> 14);
      else r = (s + 8192) >>> 14;
      if (r < -131072) r = -131072;
      if (r > 131071) r = 131071;
      return r;
   endfunction

   function automatic void halt_joint(int c);
      joint_active[c] = 0;
      joint_ticks[c] = 0;
      joint_step[c] = 0;
   endfunction

   function automatic void predict_servo(servo_cmd_type w);
      longint target, diff, dist_mag, dur, d2, span, ticks, mag, piq;
      bit busy;
      int c;
      c = w.ch;
      case (w.kind)
         msmi_pkg::KIND_TICK: begin
            for (int i = 0; i < NCH; i++) begin
               if (joint_active[i]) begin
                  if (joint_ticks[i] > 1) begin
                     joint_x[i] = clamp_x(joint_x[i] + joint_step[i]);
                     joint_ticks[i]--;
                  end else begin
                     joint_x[i] = joint_tgt[i] * 256;
                     halt_joint(i);
                  end
               end
               push_result(msmi_pkg::RS_REPORT, 5'(i), joint_x[i] >>> 8, joint_active[i],
                           i == NCH - 1);
            end
         end
         msmi_pkg::KIND_MOVE: begin
            if (c >= NCH) begin
               push_result(msmi_pkg::RS_BAD_CHANNEL, w.ch, 0, 0, 1);
               return;
            end
            target = angle_of(w.pw);
            diff = target * 256 - joint_x[c];
            dist_mag = (diff < 0) ? -diff : diff;
            dur = w.has_time ? longint'(w.mtime) << 8 : 0;
            span = span_now();
            if (w.has_speed && w.speed != 0 && span > 0) begin
               piq = (longint'(msmi_pkg::PI_Q30) + 8192) >>> 14;
               d2 = dist_mag * span * 1000 / (longint'(w.speed) * piq);
               if (d2 > dur) dur = d2;
            end
            if (dur == 0) begin
               push_result(msmi_pkg::RS_ZERO_TIME, w.ch, joint_x[c] >>> 8, joint_active[c], 1);
               return;
            end
            halt_joint(c);
            joint_tgt[c] = target;
            ticks = dur >>> 8;
            if (ticks > 65535) ticks = 65535;
            if (ticks == 0) joint_x[c] = target * 256;
            else begin
               mag = (dist_mag << 8) / dur;
               joint_step[c] = (diff < 0) ? -mag : mag;
               joint_ticks[c] = ticks;
               joint_active[c] = 1;
            end
            push_result(msmi_pkg::RS_ACCEPTED, w.ch, joint_x[c] >>> 8, joint_active[c], 1);
         end
         msmi_pkg::KIND_QUERY: begin
            busy = 0;
            for (int i = 0; i < NCH; i++) busy |= joint_active[i];
            push_result(busy ? msmi_pkg::RS_BUSY : msmi_pkg::RS_IDLE, 0, 0, 0, 1);
         end
         msmi_pkg::KIND_ESTOP: begin
            for (int i = 0; i < NCH; i++) halt_joint(i);
            push_result(msmi_pkg::RS_ACCEPTED, 0, 0, 0, 1);
         end
         msmi_pkg::KIND_STOP: begin
            if (c >= NCH) push_result(msmi_pkg::RS_BAD_CHANNEL, w.ch, 0, 0, 1);
            else if (joint_active[c]) begin
               halt_joint(c);
               push_result(msmi_pkg::RS_ACCEPTED, w.ch, joint_x[c] >>> 8, 0, 1);
            end else push_result(msmi_pkg::RS_STOP_IDLE, w.ch, joint_x[c] >>> 8, 0, 1);
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(servo_cmd_type w);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_kind = w.kind;
      req_channel = w.ch;
      req_pulse_width = w.pw;
      req_has_time = w.has_time;
      req_move_time = w.mtime;
      req_has_speed = w.has_speed;
      req_speed = w.speed;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      predict_servo(w);
      if (w.typed && servo_expected.size() > 0 && w.kind != msmi_pkg::KIND_TICK) begin
         servo_expected[$].st = w.tst;
         servo_expected[$].pos = w.tpos;
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 0;
      while (servo_expected.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [15:0] value);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_paddr = addr;
      csr_pwdata = {16'd0, value};
      csr_penable = 0;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      if (addr == ADDR_PULSE_MIN) cal_min = value;
      else cal_max = value;
   endtask

   function automatic servo_cmd_type cmd(logic [2:0] kind, logic [4:0] ch, logic [15:0] pw,
                                      logic ht, logic [15:0] mt, logic hs, logic [15:0] sp);
      servo_cmd_type w;
      w.kind = kind;
      w.ch = ch;
      w.pw = pw;
      w.has_time = ht;
      w.mtime = mt;
      w.has_speed = hs;
      w.speed = sp;
      w.typed = 0;
      w.tst = msmi_pkg::RS_REPORT;
      w.tpos = 0;
      return w;
   endfunction

   function automatic servo_cmd_type typed(servo_cmd_type w, msmi_pkg::rsp_status_type st,
                                           longint pos);
      w.typed = 1;
      w.tst = st;
      w.tpos = pos[17:0];
      return w;
   endfunction

   function automatic servo_cmd_type random_word();
      servo_cmd_type w;
      int pick;
      w = cmd(3'($urandom_range(0, 4)), 5'($urandom_range(0, NCH - 1)), 16'($urandom),
              1'($urandom), 16'($urandom_range(0, 20)), 1'($urandom),
              16'($urandom_range(0, 4000)));
      pick = $urandom_range(0, 99);
      if (pick < 35) w.kind = msmi_pkg::KIND_TICK;
      else if (pick < 75) w.kind = msmi_pkg::KIND_MOVE;
      else if (pick < 78) w.kind = KIND_BOGUS5 + 3'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) w.ch = 5'($urandom);
      if ($urandom_range(0, 1) && cal_max > cal_min)
         w.pw = 16'($urandom_range(32'(cal_min), 32'(cal_max)));
      if ($urandom_range(0, 9) == 0) w.mtime = 16'($urandom);
      if ($urandom_range(0, 7) == 0) w.speed = 16'($urandom);
      return w;
   endfunction

   initial begin
      reset = 1;
      req_valid = 0;
      req_kind = msmi_pkg::KIND_QUERY;
      req_channel = 0;
      req_pulse_width = 0;
      req_has_time = 0;
      req_move_time = 0;
      req_has_speed = 0;
      req_speed = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = ADDR_PULSE_MIN;
      csr_pwdata = 0;
      quiet = 0;
      errors = 0;
      cal_min = 500;
      cal_max = 2500;
      for (int i = 0; i < NCH; i++) begin
         joint_x[i] = 0;
         joint_tgt[i] = 0;
         halt_joint(i);
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      add_row(typed(cmd(msmi_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0), msmi_pkg::RS_IDLE, 0));
      add_row(typed(cmd(msmi_pkg::KIND_MOVE, 5'd6, 1500, 1, 10, 0, 0),
                    msmi_pkg::RS_BAD_CHANNEL, 0));
      add_row(typed(cmd(msmi_pkg::KIND_MOVE, 5'd31, 16'hFFFF, 1, 16'hFFFF, 1, 16'hFFFF),
                    msmi_pkg::RS_BAD_CHANNEL, 0));
      add_row(typed(cmd(msmi_pkg::KIND_STOP, 5'd31, 0, 0, 0, 0, 0),
                    msmi_pkg::RS_BAD_CHANNEL, 0));
      add_row(typed(cmd(msmi_pkg::KIND_STOP, 3, 0, 0, 0, 0, 0), msmi_pkg::RS_STOP_IDLE, 0));
      add_row(typed(cmd(msmi_pkg::KIND_MOVE, 0, 2500, 0, 0, 0, 0), msmi_pkg::RS_ZERO_TIME, 0));
      add_row(typed(cmd(msmi_pkg::KIND_MOVE, 0, 16'hFFFF, 1, 0, 1, 0),
                    msmi_pkg::RS_ZERO_TIME, 0));
      add_row(cmd(msmi_pkg::KIND_MOVE, 0, 0, 1, 3, 0, 0));
      add_row(cmd(msmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
      add_row(cmd(msmi_pkg::KIND_MOVE, 1, 2500, 0, 0, 1, 16'hFFFF));
      add_row(cmd(msmi_pkg::KIND_MOVE, 3, 1510, 0, 0, 1, 16'hFFFF));
      add_row(cmd(msmi_pkg::KIND_MOVE, 2, 1500, 1, 16'hFFFF, 0, 0));
      add_row(cmd(msmi_pkg::KIND_MOVE, 4, 2000, 1, 1, 1, 1));
      add_row(typed(cmd(msmi_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0), msmi_pkg::RS_BUSY, 0));
      add_row(cmd(msmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
      add_row(cmd(msmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
      add_row(cmd(msmi_pkg::KIND_STOP, 1, 0, 0, 0, 0, 0));
      add_row(cmd(msmi_pkg::KIND_MOVE, 2, 1000, 1, 5, 1, 100));
      add_row(cmd(KIND_BOGUS5, 0, 0, 0, 0, 0, 0));
      add_row(cmd(KIND_BOGUS7, 5'd31, 16'hFFFF, 1, 16'hFFFF, 1, 16'hFFFF));
      add_row(typed(cmd(msmi_pkg::KIND_ESTOP, 0, 0, 0, 0, 0, 0), msmi_pkg::RS_ACCEPTED, 0));
      add_row(cmd(msmi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
      foreach (directed[i]) send_word(directed[i]);

      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            1: begin csr_write(ADDR_PULSE_MIN, 0); csr_write(ADDR_PULSE_MAX, 16'hFFFF); end
            2: begin csr_write(ADDR_PULSE_MIN, 3000); csr_write(ADDR_PULSE_MAX, 1000); end
            3: begin
               csr_write(ADDR_PULSE_MAX, 16'hFFFF);
               csr_write(ADDR_PULSE_MIN, 16'hFFFF);
            end
            4: begin csr_write(ADDR_PULSE_MIN, 900); csr_write(ADDR_PULSE_MAX, 2100); end
            default: ;
         endcase
         quiet = (phase == 2);
         for (int n = 0; n < 60; n++) begin
            if (phase == 1 && n == 30) begin
               req_valid = 0;
               while (servo_expected.size() > 0) @(posedge clock);
               @(negedge clock);
            end
            send_word(random_word());
         end
      end
      drain();
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      servo_result_type e;
      int stall;
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         stall = quiet ? 0 : $urandom_range(0, 12);
         rsp_ready = 0;
         repeat (stall) @(negedge clock);
         rsp_ready = 1;
         do @(posedge clock); while (!rsp_valid);
         if (servo_expected.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word: status %0d ch %0d", rsp_status,
                                       rsp_report_channel);
         end else begin
            e = servo_expected.pop_front();
            if (rsp_status !== e.st || rsp_report_channel !== e.ch ||
                rsp_position !== e.pos || rsp_channel_moving !== e.moving ||
                rsp_last !== e.last) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                           e.st, e.ch, e.pos, e.moving, e.last, rsp_status,
                           rsp_report_channel, rsp_position, rsp_channel_moving, rsp_last);
            end
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
